@@ rtl/core/bfca_pkg.sv @@
// shared types, constants and codes of the best-fit coalescing allocator
package bfca_pkg;

  localparam int unsigned AddrBits  = 16;
  localparam int unsigned LenBits   = AddrBits + 1;
  localparam int unsigned StampBits = 16;
  localparam int unsigned IdxBits   = 11;

  localparam int unsigned MaxAllocsDef = 64;
  localparam int unsigned MaxFreeDef   = 65;

  localparam logic [LenBits-1:0] PoolMax = LenBits'(1) << AddrBits;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoFit    = 3'd1;
  localparam logic [2:0] StZero     = 3'd2;
  localparam logic [2:0] StNotAlloc = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [LenBits-1:0]  request_words;
    logic [AddrBits-1:0] release_addr;
  } req_t;

  typedef struct packed {
    logic [AddrBits-1:0] chunk_addr;
    logic [2:0]          status;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic [AddrBits-1:0] addr;
    logic                hit;
    logic [IdxBits-1:0]  hit_idx;
    logic [LenBits-1:0]  hit_len;
    logic                slot_ok;
    logic [IdxBits-1:0]  slot_idx;
  } used_pkt_t;

  typedef struct packed {
    logic                 valid;
    logic [LenBits-1:0]   key_a;
    logic [LenBits-1:0]   key_b;
    logic [StampBits-1:0] ctr;
    logic                 best_ok;
    logic [IdxBits-1:0]   best_idx;
    logic [LenBits-1:0]   best_len;
    logic [AddrBits-1:0]  best_start;
    logic [StampBits-1:0] best_age;
    logic                 prev_ok;
    logic [IdxBits-1:0]   prev_idx;
    logic [AddrBits-1:0]  prev_start;
    logic [LenBits-1:0]   prev_len;
    logic                 next_ok;
    logic [IdxBits-1:0]   next_idx;
    logic [LenBits-1:0]   next_len;
    logic                 slot_ok;
    logic [IdxBits-1:0]   slot_idx;
  } free_pkt_t;

  typedef struct packed {
    logic                wr;
    logic                clr;
    logic [IdxBits-1:0]  idx;
    logic [AddrBits-1:0] start;
    logic [LenBits-1:0]  len;
  } used_cmd_t;

  typedef struct packed {
    logic                 init;
    logic [LenBits-1:0]   pool;
    logic                 clr_a;
    logic [IdxBits-1:0]   clr_a_idx;
    logic                 clr_b;
    logic [IdxBits-1:0]   clr_b_idx;
    logic                 wr;
    logic [IdxBits-1:0]   wr_idx;
    logic [AddrBits-1:0]  start;
    logic [LenBits-1:0]   len;
    logic [StampBits-1:0] stamp;
  } free_cmd_t;

endpackage

@@ rtl/core/bfca_used_cell.sv @@
// one entry of the allocation table, searched as the query passes by
module bfca_used_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                init_i,
  input  bfca_pkg::used_cmd_t cmd_i,
  input  bfca_pkg::used_pkt_t pkt_i,
  output bfca_pkg::used_pkt_t pkt_o
);

  localparam logic [bfca_pkg::IdxBits-1:0] MyIdx = bfca_pkg::IdxBits'(CellIdx);

  logic                          valid_q;
  logic [bfca_pkg::AddrBits-1:0] start_q;
  logic [bfca_pkg::LenBits-1:0]  len_q;
  bfca_pkg::used_pkt_t           pkt_d, pkt_q;

  always_comb begin
    pkt_d = pkt_i;
    if (pkt_i.valid) begin
      if (valid_q && !pkt_i.hit && start_q == pkt_i.addr) begin
        pkt_d.hit     = 1'b1;
        pkt_d.hit_idx = MyIdx;
        pkt_d.hit_len = len_q;
      end
      if (!valid_q && !pkt_i.slot_ok) begin
        pkt_d.slot_ok  = 1'b1;
        pkt_d.slot_idx = MyIdx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pkt_q   <= '0;
    end else begin
      pkt_q <= pkt_d;
      if (init_i) begin
        valid_q <= 1'b0;
      end else if (cmd_i.wr && cmd_i.idx == MyIdx) begin
        valid_q <= 1'b1;
      end else if (cmd_i.clr && cmd_i.idx == MyIdx) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && cmd_i.idx == MyIdx) begin
      start_q <= cmd_i.start;
      len_q   <= cmd_i.len;
    end
  end

  assign pkt_o = pkt_q;

endmodule

@@ rtl/core/bfca_free_cell.sv @@
// one entry of the free table: best-fit and neighbour search as the query passes
module bfca_free_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfca_pkg::free_cmd_t cmd_i,
  input  bfca_pkg::free_pkt_t pkt_i,
  output bfca_pkg::free_pkt_t pkt_o
);

  localparam logic [bfca_pkg::IdxBits-1:0] MyIdx = bfca_pkg::IdxBits'(CellIdx);
  localparam logic                         IsHead = (CellIdx == 0);

  logic                           valid_q;
  logic [bfca_pkg::AddrBits-1:0]  start_q;
  logic [bfca_pkg::LenBits-1:0]   len_q;
  logic [bfca_pkg::StampBits-1:0] stamp_q;
  logic [bfca_pkg::LenBits:0]     end_sum;
  logic [bfca_pkg::StampBits-1:0] age;
  logic                           better;
  bfca_pkg::free_pkt_t            pkt_d, pkt_q;

  always_comb begin
    pkt_d   = pkt_i;
    end_sum = {2'b00, start_q} + {1'b0, len_q};
    age     = pkt_i.ctr - stamp_q;
    better  = !pkt_i.best_ok || len_q < pkt_i.best_len ||
              (len_q == pkt_i.best_len && age < pkt_i.best_age);
    if (pkt_i.valid && valid_q) begin
      if (len_q >= pkt_i.key_a && better) begin
        pkt_d.best_ok    = 1'b1;
        pkt_d.best_idx   = MyIdx;
        pkt_d.best_len   = len_q;
        pkt_d.best_start = start_q;
        pkt_d.best_age   = age;
      end
      // chunk ending at the freed start wins over one starting at its end
      if (end_sum == {1'b0, pkt_i.key_a}) begin
        pkt_d.prev_ok    = 1'b1;
        pkt_d.prev_idx   = MyIdx;
        pkt_d.prev_start = start_q;
        pkt_d.prev_len   = len_q;
      end else if ({1'b0, start_q} == pkt_i.key_b) begin
        pkt_d.next_ok  = 1'b1;
        pkt_d.next_idx = MyIdx;
        pkt_d.next_len = len_q;
      end
    end
    if (pkt_i.valid && !valid_q && !pkt_i.slot_ok) begin
      pkt_d.slot_ok  = 1'b1;
      pkt_d.slot_idx = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= IsHead;
      start_q <= '0;
      len_q   <= bfca_pkg::PoolMax;
      stamp_q <= '0;
      pkt_q   <= '0;
    end else begin
      pkt_q <= pkt_d;
      if (cmd_i.init) begin
        valid_q <= IsHead;
        start_q <= '0;
        len_q   <= cmd_i.pool;
        stamp_q <= '0;
      end else begin
        if ((cmd_i.clr_a && cmd_i.clr_a_idx == MyIdx) ||
            (cmd_i.clr_b && cmd_i.clr_b_idx == MyIdx)) begin
          valid_q <= 1'b0;
        end
        if (cmd_i.wr && cmd_i.wr_idx == MyIdx) begin
          valid_q <= 1'b1;
          start_q <= cmd_i.start;
          len_q   <= cmd_i.len;
          stamp_q <= cmd_i.stamp;
        end
      end
    end
  end

  assign pkt_o = pkt_q;

endmodule

@@ rtl/core/best_fit_coalescing_allocator_core.sv @@
// top level: best-fit pool allocator with coalescing, built on two chains of cells
// Each request runs a query through the allocation-table chain (one cell per
// cycle) and then, unless a free names an unknown address, through the
// free-table chain; the table update lands on the cycle the query leaves the
// second chain. A zero-size allocate is answered without entering either chain
// and never raises busy; otherwise busy stays high until done_o rises. The result
// is shown for one cycle with done_o and cannot be held off. Writing the pool size
// empties the allocation table and leaves one free chunk spanning the pool;
// the next request may follow on the next cycle.
module best_fit_coalescing_allocator_core #(
  parameter int unsigned MAX_ALLOCS      = bfca_pkg::MaxAllocsDef,
  parameter int unsigned MAX_FREE_CHUNKS = bfca_pkg::MaxFreeDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  bfca_pkg::req_t               req_i,
  input  logic                         cfg_we_i,
  input  logic [bfca_pkg::LenBits-1:0] cfg_wdata_i,
  output logic                         done_o,
  output bfca_pkg::rsp_t               rsp_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SUsed = 2'd1;
  localparam logic [1:0] SFree = 2'd2;

  localparam int unsigned AB = bfca_pkg::AddrBits;
  localparam int unsigned LB = bfca_pkg::LenBits;
  localparam int unsigned IB = bfca_pkg::IdxBits;

  logic [1:0]                     state_q, state_d;
  bfca_pkg::req_t                 cur_q;
  bfca_pkg::used_pkt_t            ures_q, ures_d;
  logic [bfca_pkg::StampBits-1:0] ctr_q, ctr_d;
  bfca_pkg::used_pkt_t            upk0_q, upk0_d;
  bfca_pkg::free_pkt_t            fpk0_q, fpk0_d;
  bfca_pkg::used_pkt_t            upk [MAX_ALLOCS+1];
  bfca_pkg::free_pkt_t            fpk [MAX_FREE_CHUNKS+1];
  bfca_pkg::used_cmd_t            ucmd;
  bfca_pkg::free_cmd_t            fcmd;
  logic                           done_d;
  bfca_pkg::rsp_t                 rsp_d, rsp_q;
  logic                           done_q;
  logic                           accept;
  logic [LB-1:0]                  pool_v;
  bfca_pkg::free_pkt_t            ft;
  logic [IB-1:0]                  slot_sel;
  logic                           slot_any;

  assign accept = start && !busy;
  assign ft     = fpk[MAX_FREE_CHUNKS];

  always_comb begin
    pool_v = cfg_wdata_i;
    if (pool_v == '0) begin
      pool_v = LB'(1);
    end else if (pool_v > bfca_pkg::PoolMax) begin
      pool_v = bfca_pkg::PoolMax;
    end
  end

  // lowest free-table slot once the merged neighbours are gone
  always_comb begin
    slot_any = ft.slot_ok || ft.prev_ok || ft.next_ok;
    slot_sel = {IB{1'b1}};
    if (ft.slot_ok) begin
      slot_sel = ft.slot_idx;
    end
    if (ft.prev_ok && ft.prev_idx < slot_sel) begin
      slot_sel = ft.prev_idx;
    end
    if (ft.next_ok && ft.next_idx < slot_sel) begin
      slot_sel = ft.next_idx;
    end
  end

  always_comb begin
    state_d = state_q;
    ures_d  = ures_q;
    ctr_d   = ctr_q;
    upk0_d  = '0;
    fpk0_d  = '0;
    ucmd    = '0;
    fcmd    = '0;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    fcmd.pool = pool_v;
    case (state_q)
      SIdle: begin
        if (accept) begin
          if (req_i.opcode == bfca_pkg::OpAlloc && req_i.request_words == '0) begin
            done_d           = 1'b1;
            rsp_d.chunk_addr = '0;
            rsp_d.status     = bfca_pkg::StZero;
          end else begin
            upk0_d.valid = 1'b1;
            upk0_d.addr  = req_i.release_addr;
            state_d      = SUsed;
          end
        end
      end
      SUsed: begin
        if (upk[MAX_ALLOCS].valid) begin
          ures_d = upk[MAX_ALLOCS];
          if (cur_q.opcode == bfca_pkg::OpFree && !upk[MAX_ALLOCS].hit) begin
            done_d           = 1'b1;
            rsp_d.chunk_addr = cur_q.release_addr;
            rsp_d.status     = bfca_pkg::StNotAlloc;
            state_d          = SIdle;
          end else begin
            fpk0_d.valid = 1'b1;
            fpk0_d.ctr   = ctr_q;
            fpk0_d.key_a = (cur_q.opcode == bfca_pkg::OpFree) ?
                           {1'b0, cur_q.release_addr} : cur_q.request_words;
            fpk0_d.key_b = {1'b0, cur_q.release_addr} + upk[MAX_ALLOCS].hit_len;
            state_d      = SFree;
          end
        end
      end
      SFree: begin
        if (ft.valid) begin
          done_d  = 1'b1;
          state_d = SIdle;
          if (cur_q.opcode == bfca_pkg::OpAlloc) begin
            rsp_d.chunk_addr = '0;
            if (!ft.best_ok) begin
              rsp_d.status = bfca_pkg::StNoFit;
            end else if (!ures_q.slot_ok) begin
              rsp_d.status = bfca_pkg::StFull;
            end else begin
              rsp_d.status     = bfca_pkg::StOk;
              rsp_d.chunk_addr = ft.best_start;
              ucmd.wr          = 1'b1;
              ucmd.idx         = ures_q.slot_idx;
              ucmd.start       = ft.best_start;
              ucmd.len         = cur_q.request_words;
              fcmd.clr_a       = 1'b1;
              fcmd.clr_a_idx   = ft.best_idx;
              if (ft.best_len > cur_q.request_words) begin
                fcmd.wr     = 1'b1;
                fcmd.wr_idx = ft.best_idx;
                fcmd.start  = AB'({1'b0, ft.best_start} + cur_q.request_words);
                fcmd.len    = ft.best_len - cur_q.request_words;
                fcmd.stamp  = ctr_q;
                ctr_d       = ctr_q + 1'b1;
              end
            end
          end else begin
            rsp_d.chunk_addr = cur_q.release_addr;
            if (!slot_any) begin
              rsp_d.status = bfca_pkg::StFull;
            end else begin
              rsp_d.status   = bfca_pkg::StOk;
              ucmd.clr       = 1'b1;
              ucmd.idx       = ures_q.hit_idx;
              fcmd.clr_a     = ft.prev_ok;
              fcmd.clr_a_idx = ft.prev_idx;
              fcmd.clr_b     = ft.next_ok;
              fcmd.clr_b_idx = ft.next_idx;
              fcmd.wr        = 1'b1;
              fcmd.wr_idx    = slot_sel;
              fcmd.start     = ft.prev_ok ? ft.prev_start : cur_q.release_addr;
              fcmd.len       = ures_q.hit_len + (ft.prev_ok ? ft.prev_len : '0) +
                               (ft.next_ok ? ft.next_len : '0);
              fcmd.stamp     = ctr_q;
              ctr_d          = ctr_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    if (cfg_we_i) begin
      fcmd.init = 1'b1;
      ctr_d     = bfca_pkg::StampBits'(1);
      state_d   = SIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ctr_q   <= bfca_pkg::StampBits'(1);
      upk0_q  <= '0;
      fpk0_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      upk0_q  <= upk0_d;
      fpk0_q  <= fpk0_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ures_q <= ures_d;
    rsp_q  <= rsp_d;
    if (accept) begin
      cur_q <= req_i;
    end
  end

  assign upk[0] = upk0_q;
  assign fpk[0] = fpk0_q;

  for (genvar i = 0; i < MAX_ALLOCS; i++) begin : g_used
    bfca_used_cell #(.CellIdx(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .init_i (cfg_we_i),
      .cmd_i  (ucmd),
      .pkt_i  (upk[i]),
      .pkt_o  (upk[i+1])
    );
  end

  for (genvar i = 0; i < MAX_FREE_CHUNKS; i++) begin : g_free
    bfca_free_cell #(.CellIdx(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (fcmd),
      .pkt_i  (fpk[i]),
      .pkt_o  (fpk[i+1])
    );
  end

  assign busy   = (state_q != SIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_used_tail_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    upk[MAX_ALLOCS].valid && !$past(cfg_we_i) |-> state_q == SUsed)
    else $error("allocation chain beat outside its phase");

  a_free_tail_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ft.valid && !$past(cfg_we_i) |-> state_q == SFree)
    else $error("free chain beat outside its phase");

  a_fail_addr_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == bfca_pkg::StZero || rsp_o.status == bfca_pkg::StNoFit)
    |-> rsp_o.chunk_addr == '0)
    else $error("failed allocate returned a non-zero offset");

endmodule
